/* rtl/core/sgpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_pkg
// Types and constants shared by the grazing-point filter modules.
// ----------------------------------------------------------------------------
package sgpf_pkg;

  localparam int RANGE_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int REG_W       = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int NDIG_W      = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_SQ = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COS_SQ_STEP  = 1'b1;

  localparam logic [REG_W-1:0] ONE_Q16           = 17'h10000;
  localparam logic [REG_W-1:0] THRESHOLD_SQ_RST  = 17'd45148;
  localparam logic [REG_W-1:0] COS_SQ_STEP_RST   = 17'd65535;

  // digit counts of the fixed-width multiplier operands (8-bit digits)
  localparam logic [NDIG_W-1:0] DIG_Q16 = 3'd3;   // 17-bit operand
  localparam logic [NDIG_W-1:0] DIG_K   = 3'd5;   // 33-bit operand

  localparam logic [STATUS_W-1:0] STATUS_KEPT       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FINITE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_DIFF_SQ,
    ST_LHS,
    ST_CROSS,
    ST_TU,
    ST_RHS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NDIG_W-1:0] ndig;
  } mul_ctrl_t;

endpackage

/* rtl/core/sgpf_beam_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_beam_if
// Input channel: one lidar beam per transfer.
// ----------------------------------------------------------------------------
interface sgpf_beam_if;
  logic                         valid;
  logic                         ready;
  logic [sgpf_pkg::RANGE_W-1:0] range_mm;
  logic                         finite;
  logic                         scan_end;

  modport source (output valid, range_mm, finite, scan_end, input ready);
  modport sink   (input valid, range_mm, finite, scan_end, output ready);
endinterface

/* rtl/core/sgpf_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_result_if
// Output channel: one judged beam per transfer.
// ----------------------------------------------------------------------------
interface sgpf_result_if;
  logic                          valid;
  logic                          ready;
  logic [sgpf_pkg::RANGE_W-1:0]  range_out;
  logic [sgpf_pkg::STATUS_W-1:0] status;
  logic                          last;

  modport source (output valid, range_out, status, last, input ready);
  modport sink   (input valid, range_out, status, last, output ready);
endinterface

/* rtl/core/scan_grazing_point_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_grazing_point_filter
// Marks a lidar beam removed when the segment to the next beam runs nearly
// along the line of sight. Test: 2^16*d^2*(1-t) > 4*t*(1-c)*a^2*b^2,
// d = b^2 - a^2, evaluated exactly on one shared 8-bit-digit multiplier.
// ----------------------------------------------------------------------------
// Sequence: an item that needs the grazing test makes seven passes through
//   the shared multiplier (SQ_A, SQ_B, DIFF_SQ, LHS, CROSS, TU, RHS) before
//   FINISH fills the output slots; other items go from IDLE to FINISH.
// Throughput: one item at a time; the next is taken once both output slots
//   have drained (one result transfer per cycle while the sink is ready).
// Reset: synchronous; no beam held, registers at their documented defaults.
// ----------------------------------------------------------------------------
module scan_grazing_point_filter #(
  parameter int RANGE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  sgpf_beam_if.sink                            beam_in,
  sgpf_result_if.source                        result_out,
  input  logic                                 cfg_we,
  input  logic [sgpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sgpf_pkg::REG_W-1:0]           cfg_data
);

  localparam int R      = RANGE_BITS;
  localparam int XW     = 4 * R;
  localparam int DR     = (R + 7) / 8;
  localparam int D2R    = (2 * R + 7) / 8;
  localparam int YDIG   = (D2R > 5) ? D2R : 5;
  localparam int YW     = 8 * YDIG;
  localparam int PW     = 4 * R + 33;
  localparam int CW     = 4 * R + 35;
  localparam int SH_R   = YW - 8 * DR;
  localparam int SH_2R  = YW - 8 * D2R;
  localparam int SH_Q16 = YW - 24;
  localparam int SH_K   = YW - 40;

  // configuration, stored clamped to 1.0
  logic [sgpf_pkg::REG_W-1:0] thr;
  logic [sgpf_pkg::REG_W-1:0] cos_sq;
  logic [sgpf_pkg::REG_W-1:0] cfg_clamped;

  // beam state
  logic                         held_present;
  logic                         held_finite;
  logic [sgpf_pkg::RANGE_W-1:0] held_range;
  logic [sgpf_pkg::RANGE_W-1:0] cur_range;
  logic                         cur_finite;
  logic                         cur_end;

  // output slots: slot0 the judged held beam, slot1 the final beam
  logic                          v0;
  logic                          v1;
  logic [sgpf_pkg::RANGE_W-1:0]  s0_range;
  logic [sgpf_pkg::STATUS_W-1:0] s0_status;
  logic [sgpf_pkg::STATUS_W-1:0] held_status;

  // datapath
  sgpf_pkg::state_t    state;
  sgpf_pkg::state_t    state_next;
  sgpf_pkg::mul_ctrl_t mctl;
  logic                op_busy;
  logic                mul_done;
  logic [PW-1:0]       prod;
  logic [XW-1:0]       mx;
  logic [YW-1:0]       my;
  logic [R-1:0]        a;
  logic [R-1:0]        b;
  logic [2*R-1:0]      a2;
  logic [2*R-1:0]      b2_new;
  logic [2*R-1:0]      b2_hold;
  logic [2*R-1:0]      diff;
  logic [XW-1:0]       psq;
  logic [XW+16:0]      lhs;
  logic [XW-1:0]       q;
  logic [32:0]         k;
  logic                removed;
  logic [sgpf_pkg::REG_W-1:0] w_thr;
  logic [sgpf_pkg::REG_W-1:0] u_cos;
  logic                in_xfer;
  logic                out_xfer;

  assign a      = R'(held_range);
  assign b      = R'(cur_range);
  assign w_thr  = sgpf_pkg::ONE_Q16 - thr;
  assign u_cos  = sgpf_pkg::ONE_Q16 - cos_sq;
  assign b2_new = prod[2*R-1:0];

  assign beam_in.ready = (state == sgpf_pkg::ST_IDLE) && !v0 && !v1;
  assign in_xfer       = beam_in.valid && beam_in.ready;

  assign cfg_clamped = (cfg_data > sgpf_pkg::ONE_Q16) ? sgpf_pkg::ONE_Q16 : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= sgpf_pkg::THRESHOLD_SQ_RST;
      cos_sq <= sgpf_pkg::COS_SQ_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgpf_pkg::REG_THRESHOLD_SQ: thr    <= cfg_clamped;
        sgpf_pkg::REG_COS_SQ_STEP:  cos_sq <= cfg_clamped;
        default: ;
      endcase
    end
  end

  sgpf_mul_unit #(.RANGE_BITS(RANGE_BITS)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mctl),
    .x    (mx),
    .y    (my),
    .done (mul_done),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sgpf_pkg::ST_IDLE;
      op_busy <= 1'b0;
    end else begin
      state <= state_next;
      if (mctl.start) begin
        op_busy <= 1'b1;
      end else if (mul_done) begin
        op_busy <= 1'b0;
      end
    end
  end

  // sequencer: each multiply state issues once, then waits for done
  always_comb begin
    state_next = state;
    mctl       = '0;
    mx         = '0;
    my         = '0;
    unique case (state)
      sgpf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (held_present && held_finite && beam_in.finite) begin
            state_next = sgpf_pkg::ST_SQ_A;
          end else begin
            state_next = sgpf_pkg::ST_FINISH;
          end
        end
      end
      sgpf_pkg::ST_SQ_A: begin
        mx        = XW'(a);
        my        = YW'(a) << SH_R;
        mctl.ndig = sgpf_pkg::NDIG_W'(DR);
        if (mul_done) state_next = sgpf_pkg::ST_SQ_B;
      end
      sgpf_pkg::ST_SQ_B: begin
        mx        = XW'(b);
        my        = YW'(b) << SH_R;
        mctl.ndig = sgpf_pkg::NDIG_W'(DR);
        if (mul_done) state_next = sgpf_pkg::ST_DIFF_SQ;
      end
      sgpf_pkg::ST_DIFF_SQ: begin
        mx        = XW'(diff);
        my        = YW'(diff) << SH_2R;
        mctl.ndig = sgpf_pkg::NDIG_W'(D2R);
        if (mul_done) state_next = sgpf_pkg::ST_LHS;
      end
      sgpf_pkg::ST_LHS: begin
        mx        = psq;
        my        = YW'(w_thr) << SH_Q16;
        mctl.ndig = sgpf_pkg::DIG_Q16;
        if (mul_done) state_next = sgpf_pkg::ST_CROSS;
      end
      sgpf_pkg::ST_CROSS: begin
        mx        = XW'(a2);
        my        = YW'(b2_hold) << SH_2R;
        mctl.ndig = sgpf_pkg::NDIG_W'(D2R);
        if (mul_done) state_next = sgpf_pkg::ST_TU;
      end
      sgpf_pkg::ST_TU: begin
        mx        = XW'(thr);
        my        = YW'(u_cos) << SH_Q16;
        mctl.ndig = sgpf_pkg::DIG_Q16;
        if (mul_done) state_next = sgpf_pkg::ST_RHS;
      end
      sgpf_pkg::ST_RHS: begin
        mx        = q;
        my        = YW'(k) << SH_K;
        mctl.ndig = sgpf_pkg::DIG_K;
        if (mul_done) state_next = sgpf_pkg::ST_FINISH;
      end
      sgpf_pkg::ST_FINISH: begin
        state_next = sgpf_pkg::ST_IDLE;
      end
      default: begin
        state_next = sgpf_pkg::ST_IDLE;
      end
    endcase
    mctl.start = (state != sgpf_pkg::ST_IDLE) && (state != sgpf_pkg::ST_FINISH) && !op_busy;
  end

  // product captures
  always_ff @(posedge clk) begin
    if (mul_done) begin
      unique case (state)
        sgpf_pkg::ST_SQ_A: a2 <= prod[2*R-1:0];
        sgpf_pkg::ST_SQ_B: begin
          b2_hold <= b2_new;
          diff    <= (b2_new > a2) ? b2_new - a2 : a2 - b2_new;
        end
        sgpf_pkg::ST_DIFF_SQ: psq <= prod[XW-1:0];
        sgpf_pkg::ST_LHS:     lhs <= prod[XW+16:0];
        sgpf_pkg::ST_CROSS:   q   <= prod[XW-1:0];
        sgpf_pkg::ST_TU:      k   <= prod[32:0];
        sgpf_pkg::ST_RHS:     removed <= (CW'({lhs, 16'd0}) > {prod, 2'd0});
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!held_finite) begin
      held_status = sgpf_pkg::STATUS_NOT_FINITE;
    end else if (cur_finite && removed) begin
      held_status = sgpf_pkg::STATUS_REMOVED;
    end else begin
      held_status = sgpf_pkg::STATUS_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_range  <= beam_in.range_mm;
      cur_finite <= beam_in.finite;
      cur_end    <= beam_in.scan_end;
    end
    if (state == sgpf_pkg::ST_FINISH) begin
      s0_range  <= held_range;
      s0_status <= held_status;
    end
  end

  assign out_xfer = result_out.valid && result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_present <= 1'b0;
      held_finite  <= 1'b0;
      held_range   <= '0;
      v0           <= 1'b0;
      v1           <= 1'b0;
    end else if (state == sgpf_pkg::ST_FINISH) begin
      // slots are empty here: an item is only taken with both drained
      v0 <= held_present;
      v1 <= cur_end;
      if (cur_end) begin
        held_present <= 1'b0;
        held_finite  <= 1'b0;
        held_range   <= '0;
      end else begin
        held_present <= 1'b1;
        held_finite  <= cur_finite;
        held_range   <= cur_range;
      end
    end else if (out_xfer) begin
      if (v0) begin
        v0 <= 1'b0;
      end else begin
        v1 <= 1'b0;
      end
    end
  end

  assign result_out.valid     = v0 || v1;
  assign result_out.range_out = v0 ? s0_range : cur_range;
  assign result_out.status    = v0 ? s0_status
                              : (cur_finite ? sgpf_pkg::STATUS_KEPT
                                            : sgpf_pkg::STATUS_NOT_FINITE);
  assign result_out.last      = !v0;

endmodule

/* rtl/core/sgpf_mul_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_mul_unit
// Shared multiplier: wide x times y, one 8-bit digit of y per cycle, MSB
// first. y comes left-aligned; ndig digits are consumed.
// ----------------------------------------------------------------------------
module sgpf_mul_unit #(
  parameter int RANGE_BITS = 16,
  localparam int XW   = 4 * RANGE_BITS,
  localparam int D2R  = (2 * RANGE_BITS + 7) / 8,
  localparam int YDIG = (D2R > 5) ? D2R : 5,
  localparam int YW   = 8 * YDIG,
  localparam int PW   = 4 * RANGE_BITS + 33
) (
  input  logic                clk,
  input  logic                rst,
  input  sgpf_pkg::mul_ctrl_t ctrl,
  input  logic [XW-1:0]       x,
  input  logic [YW-1:0]       y,
  output logic                done,
  output logic [PW-1:0]       prod
);

  logic [XW-1:0]               x_reg;
  logic [YW-1:0]               y_reg;
  logic [PW-1:0]               acc;
  logic [sgpf_pkg::NDIG_W-1:0] cnt;
  logic                        busy;
  logic [XW+7:0]               partial;
  logic [PW-1:0]               acc_next;

  assign partial  = (XW+8)'(x_reg) * (XW+8)'(y_reg[YW-1 -: 8]);
  assign acc_next = {acc[PW-9:0], 8'd0} + PW'(partial);
  assign prod     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == sgpf_pkg::NDIG_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x_reg <= x;
      y_reg <= y;
      acc   <= '0;
      cnt   <= ctrl.ndig;
    end else if (busy) begin
      acc   <= acc_next;
      y_reg <= {y_reg[YW-9:0], 8'd0};
      cnt   <= cnt - sgpf_pkg::NDIG_W'(1);
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for scan_grazing_point_filter. Beams are fed as short
// scans, both directed and random, under several threshold and beam-angle
// settings. A scoreboard predicts each judged beam and checks it against
// the result channel. Both channels idle at random outside one steady phase.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANGE_BITS = 16;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [sgpf_pkg::RANGE_W-1:0] range_mm;
    logic                         finite;
    logic                         scan_end;
  } beam_t;

  typedef struct packed {
    logic [sgpf_pkg::RANGE_W-1:0]  range_out;
    logic [sgpf_pkg::STATUS_W-1:0] status;
    logic                          last;
  } judged_t;

  class grazing_scoreboard;
    judged_t                      pending[$];
    logic [sgpf_pkg::REG_W-1:0]   thresh_sq = sgpf_pkg::THRESHOLD_SQ_RST;
    logic [sgpf_pkg::REG_W-1:0]   cos_sq = sgpf_pkg::COS_SQ_STEP_RST;
    logic [sgpf_pkg::RANGE_W-1:0] held_range = '0;
    logic                         held_finite = 1'b0;
    logic                         held_present = 1'b0;
    int                           errors = 0;
    int                           beams = 0;
    int                           status_seen[3] = '{0, 0, 0};
    int                           ends_seen = 0;

    function void set_reg(logic [sgpf_pkg::CFG_INDEX_W-1:0] idx,
                          logic [sgpf_pkg::REG_W-1:0] val);
      if (idx == sgpf_pkg::REG_THRESHOLD_SQ) thresh_sq = val;
      else if (idx == sgpf_pkg::REG_COS_SQ_STEP) cos_sq = val;
    endfunction

    // Exact cross-multiplied form of the grazing test; 128 bits is ample
    // for 16-bit ranges.
    function bit grazes(logic [sgpf_pkg::RANGE_W-1:0] r1, logic [sgpf_pkg::RANGE_W-1:0] r2);
      logic [127:0] a, b, a2, b2, diff, sum, lhs, den, tt, cc, mask;
      mask = (128'd1 << RANGE_BITS) - 128'd1;
      a = {112'd0, r1} & mask;
      b = {112'd0, r2} & mask;
      a2 = a * a;
      b2 = b * b;
      diff = (b2 > a2) ? b2 - a2 : a2 - b2;
      sum = a2 + b2;
      tt = (thresh_sq > sgpf_pkg::ONE_Q16) ? {111'd0, sgpf_pkg::ONE_Q16}
                                           : {111'd0, thresh_sq};
      cc = (cos_sq > sgpf_pkg::ONE_Q16) ? {111'd0, sgpf_pkg::ONE_Q16}
                                        : {111'd0, cos_sq};
      lhs = (diff * diff) << 32;
      den = ((sum * sum) << 16) - (a2 * b2) * (cc << 2);
      if (den == 0) return 1'b0;
      return lhs > den * tt;
    endfunction

    function void note_beam(beam_t bm);
      judged_t r;
      beams++;
      if (held_present) begin
        r.range_out = held_range;
        r.last = 1'b0;
        if (!held_finite) r.status = sgpf_pkg::STATUS_NOT_FINITE;
        else if (!bm.finite) r.status = sgpf_pkg::STATUS_KEPT;
        else r.status = grazes(held_range, bm.range_mm) ? sgpf_pkg::STATUS_REMOVED
                                                        : sgpf_pkg::STATUS_KEPT;
        pending.push_back(r);
      end
      if (bm.scan_end) begin
        r.range_out = bm.range_mm;
        r.status = bm.finite ? sgpf_pkg::STATUS_KEPT : sgpf_pkg::STATUS_NOT_FINITE;
        r.last = 1'b1;
        pending.push_back(r);
        held_present = 1'b0;
        held_range = '0;
        held_finite = 1'b0;
      end else begin
        held_present = 1'b1;
        held_range = bm.range_mm;
        held_finite = bm.finite;
      end
    endfunction

    function void check_result(judged_t got);
      judged_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result range=%0d status=%0d last=%0b",
                   $realtime, got.range_out, got.status, got.last);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.status <= sgpf_pkg::STATUS_NOT_FINITE) status_seen[exp_r.status]++;
      if (exp_r.last) ends_seen++;
      if (got.range_out !== exp_r.range_out || got.status !== exp_r.status ||
          got.last !== exp_r.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp range/status/last=%0d/%0d/%0b, got %0d/%0d/%0b",
                   $realtime, exp_r.range_out, exp_r.status, exp_r.last,
                   got.range_out, got.status, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [sgpf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sgpf_pkg::REG_W-1:0] cfg_data;
  bit steady = 1'b0;
  int settings_run = 1;

  grazing_scoreboard sb = new();

  sgpf_beam_if   beam_bus();
  sgpf_result_if result_bus();

  scan_grazing_point_filter #(
    .RANGE_BITS(RANGE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .beam_in   (beam_bus),
    .result_out(result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      sb.check_result('{result_bus.range_out, result_bus.status, result_bus.last});
    result_bus.ready <= steady || ($urandom_range(99) >= 23);
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_beam(input beam_t bm);
    while (!steady && $urandom_range(99) < 23) begin
      beam_bus.valid <= 1'b0;
      @(posedge clk);
    end
    beam_bus.valid <= 1'b1;
    beam_bus.range_mm <= bm.range_mm;
    beam_bus.finite <= bm.finite;
    beam_bus.scan_end <= bm.scan_end;
    do @(posedge clk); while (!beam_bus.ready);
    sb.note_beam(bm);
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic drain();
    beam_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sgpf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sgpf_pkg::REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input logic [sgpf_pkg::REG_W-1:0] thr,
                            input logic [sgpf_pkg::REG_W-1:0] cs);
    write_reg(sgpf_pkg::REG_THRESHOLD_SQ, thr);
    write_reg(sgpf_pkg::REG_COS_SQ_STEP, cs);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  function automatic logic [sgpf_pkg::RANGE_W-1:0] pick_range(
      logic [sgpf_pkg::RANGE_W-1:0] prev);
    int d;
    d = int'(prev);
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1: return prev;
      2, 3, 4: begin
        d = d + int'($urandom_range(600)) - 300;
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return d[sgpf_pkg::RANGE_W-1:0];
      end
      default: return sgpf_pkg::RANGE_W'($urandom_range(65535));
    endcase
  endfunction

  // random scans of 1..12 beams, each closed by a scan end
  task automatic run_scans(input int count);
    int sent;
    int len;
    beam_t bm;
    logic [sgpf_pkg::RANGE_W-1:0] prev;
    sent = 0;
    prev = sgpf_pkg::RANGE_W'($urandom_range(65535));
    while (sent < count) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        bm.range_mm = pick_range(prev);
        prev = bm.range_mm;
        bm.finite = ($urandom_range(9) != 0);
        bm.scan_end = (k == len - 1);
        send_beam(bm);
        sent++;
      end
      if ($urandom_range(14) == 0) drain();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= sgpf_pkg::REG_THRESHOLD_SQ;
    cfg_data <= '0;
    beam_bus.valid <= 1'b0;
    beam_bus.range_mm <= '0;
    beam_bus.finite <= 1'b0;
    beam_bus.scan_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero denominator, non-finite neighbors, lone beams
    send_beam('{16'd0, 1'b1, 1'b0});
    send_beam('{16'd0, 1'b1, 1'b0});
    send_beam('{16'hFFFF, 1'b1, 1'b0});
    send_beam('{16'hFFFF, 1'b1, 1'b0});
    send_beam('{16'd30000, 1'b0, 1'b0});
    send_beam('{16'd12345, 1'b1, 1'b0});
    send_beam('{16'd12400, 1'b1, 1'b0});
    send_beam('{16'd12401, 1'b1, 1'b1});
    send_beam('{16'd777, 1'b1, 1'b1});
    send_beam('{16'hFFFF, 1'b0, 1'b1});
    send_beam('{16'd5000, 1'b1, 1'b0});
    send_beam('{16'd5000, 1'b0, 1'b1});
    send_beam('{16'd0, 1'b0, 1'b0});
    send_beam('{16'd0, 1'b1, 1'b1});
    send_beam('{16'd40000, 1'b1, 1'b0});
    send_beam('{16'd20000, 1'b1, 1'b0});
    send_beam('{16'd20100, 1'b1, 1'b0});
    send_beam('{16'hFFFF, 1'b1, 1'b1});
    run_scans(90);
    settle();

    // cos^2 at full scale makes equal ranges a zero denominator
    set_config(17'd65536, 17'd65536);
    send_beam('{16'd3000, 1'b1, 1'b0});
    send_beam('{16'd3000, 1'b1, 1'b1});
    run_scans(90);
    settle();

    set_config(17'd0, 17'd65535);
    run_scans(90);
    settle();

    // register values beyond one saturate; this phase runs without idling
    steady = 1'b1;
    set_config(17'h1FFFF, 17'h1FFFF);
    run_scans(90);
    settle();
    steady = 1'b0;

    set_config(sgpf_pkg::THRESHOLD_SQ_RST, 17'd0);
    run_scans(90);
    settle();

    set_config(sgpf_pkg::REG_W'($urandom_range(131071)),
               sgpf_pkg::REG_W'($urandom_range(131071)));
    run_scans(90);
    settle();

    set_config(17'd30000, 17'd64000);
    run_scans(90);
    settle();

    $display("Run covered %0d beams under %0d register settings.", sb.beams, settings_run);
    $display("Results checked: %0d kept, %0d removed, %0d not finite, %0d scan ends.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.ends_seen);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
